// ===== rtl/ffha_pkg.sv =====
// Shared constants, types and helpers for the first-fit heap allocator.
package ffha_pkg;

	localparam int GRAN_BYTES = 16;
	localparam int GRAN_SHIFT = 4;
	localparam int HDR_BYTES  = 8;
	localparam int BYTES_W    = 12;
	localparam int OFF_W      = 12;
	localparam int NEED_W     = 9;

	localparam logic REQ_FREE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_INVALID  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_NEXT,
		S_SPLIT,
		S_RESP
	} state_t;

	// ceil((bytes + header) / granule)
	function automatic logic [NEED_W-1:0] granules_needed(input logic [BYTES_W-1:0] bytes);
		logic [BYTES_W:0] sum;
		sum = {1'b0, bytes} + (BYTES_W+1)'(HDR_BYTES + GRAN_BYTES - 1);
		return sum[BYTES_W:GRAN_SHIFT];
	endfunction

endpackage

// ===== rtl/ffha_req_if.sv =====
// Request channel of the heap allocator.
interface ffha_req_if;
	import ffha_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [BYTES_W-1:0]   alloc_bytes;
	logic [BYTES_W-1:0]   free_offset;

	modport source(output valid, req_type, alloc_bytes, free_offset, input ready);
	modport sink(input valid, req_type, alloc_bytes, free_offset, output ready);
endinterface

// ===== rtl/ffha_rsp_if.sv =====
// Response channel of the heap allocator.
interface ffha_rsp_if;
	import ffha_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic [OFF_W-1:0]   payload_offset;

	modport source(output valid, status, payload_offset, input ready);
	modport sink(input valid, status, payload_offset, output ready);
endinterface

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator over an implicit block list held in a header memory.
//
//  channel | side   | payload
//  --------+--------+---------------------------------------
//  req     | sink   | req_type, alloc_bytes, free_offset
//  rsp     | source | status, payload_offset
//
// A request walks the block list one block header per cycle from the header
// memory. A split alloc or a successful free adds a write state after the walk
// (S_SPLIT or S_NEXT) before the response is loaded.
// Reset needs no clearing pass; entry zero reads as the whole-heap block until written.
// A new request is taken once the previous one has reached the output register.
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	ffha_req_if.sink   req,
	ffha_rsp_if.source rsp
);
	import ffha_pkg::*;

	localparam int GRANULES = HEAP_BYTES / GRAN_BYTES;
	localparam int PW = $clog2(GRANULES);
	localparam int AW = PW + 1;
	localparam int HW = AW + 1;
	localparam int CW = (AW > NEED_W) ? AW : NEED_W;
	localparam int OW = (PW + GRAN_SHIFT > OFF_W) ? PW + GRAN_SHIFT : OFF_W;
	localparam logic [AW-1:0] GRAN_CNT = AW'(GRANULES);

	state_t state_q, state_d;

	logic              op_q;
	logic [NEED_W-1:0] need_q;
	logic [OFF_W-1:0]  off_q;
	logic [AW-1:0]     pos_q;
	logic [AW-1:0]     len_q;
	logic [PW-1:0]     prev_pos_q;
	logic [AW-1:0]     prev_len_q;
	logic              prev_used_q;
	logic              have_prev_q;
	logic              nxt_ok_q;
	status_t           res_status_q;
	logic [OFF_W-1:0]  res_off_q;

	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [OFF_W-1:0]  rsp_off_q;

	logic              rd_en;
	logic [PW-1:0]     rd_addr;
	logic [PW-1:0]     rd_addr_s1;
	logic [HW-1:0]     rd_data;
	logic              wr_en;
	logic [PW-1:0]     wr_addr;
	logic [HW-1:0]     wr_data;

	logic              cur_used;
	logic [AW-1:0]     cur_n;
	logic [AW-1:0]     room;
	logic [AW-1:0]     cur_len;
	logic [OW-1:0]     cur_off;
	logic              hit_off;
	logic              fits;
	logic              split;
	logic [AW-1:0]     next_pos;
	logic              next_end;
	logic [AW-1:0]     nxt_len;
	logic [AW-1:0]     tot_len;
	logic [AW-1:0]     merged_len;
	logic [AW-1:0]     split_pos;
	logic              rsp_load;

	ffha_hdr_mem #(
		.DEPTH(GRANULES),
		.HW   (HW)
	) u_hdr_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// header decode; zero or oversized lengths reach to the heap end
	assign cur_used = rd_data[0];
	assign cur_n    = rd_data[HW-1:1];
	assign room     = GRAN_CNT - {1'b0, rd_addr_s1};
	assign cur_len  = (cur_n == '0 || cur_n > room) ? room : cur_n;
	assign cur_off  = OW'({rd_addr_s1, GRAN_SHIFT'(HDR_BYTES)});
	assign hit_off  = (cur_off == OW'(off_q));
	assign fits     = (CW'(cur_len) >= CW'(need_q));
	assign split    = (CW'(cur_len) > CW'(need_q));
	assign next_pos = pos_q + cur_len;
	assign next_end = (next_pos >= GRAN_CNT);

	assign nxt_len    = (nxt_ok_q && !cur_used) ? cur_len : '0;
	assign tot_len    = len_q + nxt_len;
	assign merged_len = prev_len_q + tot_len;
	assign split_pos  = pos_q + AW'(need_q);

	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		req.ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					rd_en   = 1'b1;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (op_q == REQ_FREE) begin
					if (hit_off) begin
						if (!cur_used) begin
							state_d = S_RESP;
						end else begin
							rd_en   = !next_end;
							rd_addr = next_pos[PW-1:0];
							state_d = S_NEXT;
						end
					end else if (next_end) begin
						state_d = S_RESP;
					end else begin
						rd_en   = 1'b1;
						rd_addr = next_pos[PW-1:0];
					end
				end else begin
					if (!cur_used && fits) begin
						wr_en   = 1'b1;
						wr_addr = pos_q[PW-1:0];
						wr_data = {AW'(need_q), 1'b1};
						state_d = split ? S_SPLIT : S_RESP;
					end else if (next_end) begin
						state_d = S_RESP;
					end else begin
						rd_en   = 1'b1;
						rd_addr = next_pos[PW-1:0];
					end
				end
			end
			S_NEXT: begin
				wr_en = 1'b1;
				if (have_prev_q && !prev_used_q) begin
					wr_addr = prev_pos_q;
					wr_data = {merged_len, 1'b0};
				end else begin
					wr_addr = pos_q[PW-1:0];
					wr_data = {tot_len, 1'b0};
				end
				state_d = S_RESP;
			end
			S_SPLIT: begin
				wr_en   = 1'b1;
				wr_addr = split_pos[PW-1:0];
				wr_data = {len_q - AW'(need_q), 1'b0};
				state_d = S_RESP;
			end
			S_RESP: begin
				if (rsp_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_addr_s1 <= rd_addr;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_q        <= req.req_type;
					need_q      <= granules_needed(req.alloc_bytes);
					off_q       <= req.free_offset;
					pos_q       <= '0;
					have_prev_q <= 1'b0;
				end
			end
			S_WALK: begin
				if (op_q == REQ_FREE) begin
					if (hit_off) begin
						len_q        <= cur_len;
						nxt_ok_q     <= !next_end;
						res_status_q <= cur_used ? ST_OK : ST_INVALID;
						res_off_q    <= '0;
					end else begin
						prev_pos_q  <= rd_addr_s1;
						prev_len_q  <= cur_len;
						prev_used_q <= cur_used;
						have_prev_q <= 1'b1;
						pos_q       <= next_pos;
						if (next_end) begin
							res_status_q <= ST_INVALID;
							res_off_q    <= '0;
						end
					end
				end else begin
					if (!cur_used && fits) begin
						len_q        <= cur_len;
						res_status_q <= ST_OK;
						res_off_q    <= cur_off[OFF_W-1:0];
					end else begin
						pos_q <= next_pos;
						if (next_end) begin
							res_status_q <= ST_NO_SPACE;
							res_off_q    <= '0;
						end
					end
				end
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_off_q    <= res_off_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (rsp_load)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.payload_offset = rsp_off_q;

`ifndef SYNTHESIS
	a_offset_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.payload_offset == '0))
		else $error("nonzero payload offset on failed request");

	a_walk_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (pos_q < GRAN_CNT))
		else $error("walk position past heap end");

	a_walk_addr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (rd_addr_s1 == pos_q[PW-1:0]))
		else $error("header read does not match walk position");

	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_WALK))
		else $error("accepted request did not start a walk");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_WALK || state_q == S_NEXT || state_q == S_SPLIT))
		else $error("header write outside update states");
`endif

endmodule

// ===== rtl/ffha_hdr_mem.sv =====
// Block header memory with a registered read; entry zero reads as the whole heap until written.
module ffha_hdr_mem #(
	parameter int DEPTH = 256,
	parameter int HW    = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [HW-1:0]            rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [HW-1:0]            wr_data
);
	localparam logic [HW-1:0] RESET_HDR = {(HW-1)'(DEPTH), 1'b0};

	logic [HW-1:0] mem [DEPTH];
	logic [HW-1:0] rd_q;
	logic          init_q;
	logic          rd_init_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	// only entry zero is ever read before it is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= 1'b1;
			rd_init_s1 <= 1'b0;
		end else begin
			if (wr_en && wr_addr == '0)
				init_q <= 1'b0;
			if (rd_en)
				rd_init_s1 <= init_q && (rd_addr == '0);
		end
	end

	assign rd_data = rd_init_s1 ? RESET_HDR : rd_q;

endmodule

// ===== dv/first_fit_heap_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit heap allocator: directed and random alloc/free traffic.
module first_fit_heap_allocator_tb;
	import ffha_pkg::*;

	localparam int HEAP_BYTES = 4096;
	localparam int GRANULES   = HEAP_BYTES / GRAN_BYTES;
	localparam int LEN_W      = 9;
	localparam logic REQ_ALLOC = 1'b0;
	localparam int RANDOM_REQS = 1230;
	localparam int DRAIN_WAIT  = GRANULES + 40;
	localparam int CYCLE_LIMIT = 1_500_000;

	typedef struct packed {
		status_t          status;
		logic [OFF_W-1:0] offset;
	} heap_reply_t;

	logic clk;
	logic arst_n;

	ffha_req_if req_ch();
	ffha_rsp_if rsp_ch();

	first_fit_heap_allocator #(
		.HEAP_BYTES(HEAP_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// header image: {length in granules, allocated}
	logic [LEN_W:0] heap_hdr [GRANULES];
	int             live_offsets[$];
	heap_reply_t    pending_replies[$];
	int             error_count;
	int             cycle_count;
	int             burst_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL first_fit_heap_allocator");
			$finish;
		end
	end

	function automatic int block_len(int pos);
		int n;
		int room;
		n = int'(heap_hdr[pos][LEN_W:1]);
		room = GRANULES - pos;
		if (n == 0 || n > room)
			n = room;
		return n;
	endfunction

	function automatic heap_reply_t predict_alloc(logic [BYTES_W-1:0] bytes);
		heap_reply_t r;
		int need;
		int pos;
		int len;
		r.status = ST_NO_SPACE;
		r.offset = '0;
		need = (int'(bytes) + HDR_BYTES + GRAN_BYTES - 1) / GRAN_BYTES;
		pos = 0;
		while (pos < GRANULES) begin
			len = block_len(pos);
			if (!heap_hdr[pos][0] && len >= need) begin
				if (len > need)
					heap_hdr[pos + need] = (LEN_W+1)'((len - need) << 1);
				heap_hdr[pos] = (LEN_W+1)'((need << 1) | 1);
				r.status = ST_OK;
				r.offset = OFF_W'(pos * GRAN_BYTES + HDR_BYTES);
				live_offsets.push_back(pos * GRAN_BYTES + HDR_BYTES);
				return r;
			end
			pos += len;
		end
		return r;
	endfunction

	function automatic heap_reply_t predict_free(logic [OFF_W-1:0] off);
		heap_reply_t r;
		int pos;
		int prev;
		int len;
		int nxt;
		bit have_prev;
		r.status = ST_INVALID;
		r.offset = '0;
		pos = 0;
		prev = 0;
		have_prev = 1'b0;
		while (pos < GRANULES) begin
			len = block_len(pos);
			if (pos * GRAN_BYTES + HDR_BYTES == int'(off)) begin
				if (!heap_hdr[pos][0])
					return r;
				nxt = pos + len;
				if (nxt < GRANULES && !heap_hdr[nxt][0]) begin
					len += block_len(nxt);
					heap_hdr[nxt] = '0;
				end
				if (have_prev && !heap_hdr[prev][0]) begin
					heap_hdr[prev] = (LEN_W+1)'((block_len(prev) + len) << 1);
					heap_hdr[pos] = '0;
				end else begin
					heap_hdr[pos] = (LEN_W+1)'(len << 1);
				end
				r.status = ST_OK;
				for (int i = 0; i < live_offsets.size(); i++) begin
					if (live_offsets[i] == int'(off)) begin
						live_offsets.delete(i);
						break;
					end
				end
				return r;
			end
			prev = pos;
			have_prev = 1'b1;
			pos += len;
		end
		return r;
	endfunction

	// one request transfer; the sender runs in bursts with random gaps
	task automatic send_request(input logic kind, input logic [BYTES_W-1:0] bytes,
			input logic [OFF_W-1:0] off);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
		burst_left--;
		req_ch.valid       = 1'b1;
		req_ch.req_type    = kind;
		req_ch.alloc_bytes = bytes;
		req_ch.free_offset = off;
		do @(posedge clk); while (!req_ch.ready);
		if (kind == REQ_FREE)
			pending_replies.push_back(predict_free(off));
		else
			pending_replies.push_back(predict_alloc(bytes));
	endtask

	task automatic alloc_req(input int bytes);
		send_request(REQ_ALLOC, BYTES_W'(bytes), OFF_W'($urandom_range(4095)));
	endtask

	task automatic free_req(input int off);
		send_request(REQ_FREE, BYTES_W'($urandom_range(4095)), OFF_W'(off));
	endtask

	task automatic test_whole_heap();
		alloc_req(4088);   // exactly the whole heap
		alloc_req(0);      // nothing left, even for a header-only block
		free_req(8);
		alloc_req(4095);   // one granule too many
		alloc_req(4089);
	endtask

	task automatic test_bad_pointers();
		alloc_req(0);
		free_req(8);
		free_req(8);       // double free
		free_req(0);
		free_req(4095);
		free_req(24);      // inside a block, not a payload start
	endtask

	task automatic test_coalescing();
		alloc_req(24);
		alloc_req(24);
		alloc_req(24);
		alloc_req(24);
		free_req(8);
		free_req(72);
		free_req(40);      // free on both sides
		free_req(104);     // free predecessor and free tail
	endtask

	task automatic test_first_fit();
		alloc_req(40);
		alloc_req(8);
		alloc_req(40);
		free_req(8);
		alloc_req(0);      // lands in the hole, splits it
		alloc_req(24);     // fits the rest of the hole exactly
	endtask

	task automatic test_random_traffic();
		int alloc_pct;
		int pick;
		int sz;
		alloc_pct = 70;
		for (int i = 0; i < RANDOM_REQS; i++) begin
			// alternate fill and drain phases to reach both a full and an empty heap
			if (i % 100 == 0)
				alloc_pct = ((i / 100) % 2 == 0) ? 70 : 30;
			if ($urandom_range(99) < alloc_pct) begin
				pick = $urandom_range(9);
				if (pick < 7)
					sz = $urandom_range(127);
				else if (pick < 9)
					sz = $urandom_range(1023);
				else
					sz = $urandom_range(4095);
				alloc_req(sz);
			end else begin
				pick = $urandom_range(9);
				if (pick < 7 && live_offsets.size() != 0)
					free_req(live_offsets[$urandom_range(live_offsets.size() - 1)]);
				else if (pick < 9)
					free_req($urandom_range(GRANULES - 1) * GRAN_BYTES + HDR_BYTES);
				else
					free_req($urandom_range(4095));
			end
		end
	endtask

	// response sink: stall pattern changes mode every so often
	initial begin
		int mode_left;
		int ready_pct;
		rsp_ch.ready = 1'b0;
		mode_left = 0;
		ready_pct = 100;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode_left = $urandom_range(16, 200);
				case ($urandom_range(3))
					0: ready_pct = 100;
					1: ready_pct = 70;
					2: ready_pct = 40;
					default: ready_pct = 10;
				endcase
			end
			mode_left--;
			rsp_ch.ready = ($urandom_range(99) < ready_pct);
		end
	end

	always @(posedge clk) begin
		heap_reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected response transfer: status %0d, payload_offset %0d",
					rsp_ch.status, rsp_ch.payload_offset);
				error_count++;
			end else begin
				want = pending_replies.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.payload_offset !== want.offset) begin
					$error("payload_offset: expected %0d, actual %0d",
						want.offset, rsp_ch.payload_offset);
					error_count++;
				end
			end
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		burst_left  = 0;
		arst_n = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_ALLOC;
		req_ch.alloc_bytes = '0;
		req_ch.free_offset = '0;
		foreach (heap_hdr[i])
			heap_hdr[i] = '0;
		heap_hdr[0] = (LEN_W+1)'(GRANULES << 1);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_whole_heap();
		test_bad_pointers();
		test_coalescing();
		test_first_fit();
		test_random_traffic();

		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("PASS first_fit_heap_allocator");
		else
			$display("FAIL first_fit_heap_allocator");
		$finish;
	end

endmodule
